/* rtl/brs_pkg.sv */
// brs_pkg: shared constants, types and codes for the billboard row scaler.
// Used by brs_ctrl, brs_dpath and billboard_row_scaler; depends on nothing.

package brs_pkg;

    // Store and height limits
    localparam int SPRITE_DEPTH = 32;
    localparam int MAX_HEIGHT   = 64;

    // Derived widths
    localparam int IDX_W  = $clog2(SPRITE_DEPTH);      // store address
    localparam int RW     = $clog2(SPRITE_DEPTH + 1);  // rows in use after saturation
    localparam int FRAC_W = 8;                          // fraction bits of the row step
    localparam int NUM_W  = RW + FRAC_W;                // step and accumulator
    localparam int HGT_W  = $clog2(MAX_HEIGHT + 1);    // saturated height
    localparam int DCNT_W = $clog2(NUM_W);              // divider step counter
    localparam int HX_W   = 10;                         // signed working width for hpos

    // Fixed field widths
    localparam int ROW_W   = 8;
    localparam int PIX_W   = 8;
    localparam int SLOT_W  = 2;
    localparam int SIZE_W  = 2;
    localparam int LIDX_W  = 5;
    localparam int TOP_W   = 7;
    localparam int RIU_W   = 6;
    localparam int CFG_W   = 8;

    // Width code thresholds and pixel widths
    localparam int QUAD_MIN   = 48;
    localparam int DOUBLE_MIN = 24;
    localparam int WIDTH_QUAD   = 32;
    localparam int WIDTH_DOUBLE = 16;
    localparam int WIDTH_SINGLE = 8;
    localparam int HPOS_BASE    = 48;

    localparam logic [SIZE_W-1:0] SIZE_SINGLE = 2'd0;
    localparam logic [SIZE_W-1:0] SIZE_DOUBLE = 2'd1;
    localparam logic [SIZE_W-1:0] SIZE_QUAD   = 2'd3;

    // Stream command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_DRAW = 1'b1;

    // Register map
    localparam int REG_ADDR_W = 4;
    localparam logic [1:0] REG_VIEW_LEFT  = 2'd0;
    localparam logic [1:0] REG_VIEW_RIGHT = 2'd1;
    localparam logic [1:0] REG_TOP_OFFSET = 2'd2;

    localparam logic [CFG_W-1:0] VIEW_LEFT_RST  = 8'd20;
    localparam logic [CFG_W-1:0] VIEW_RIGHT_RST = 8'd159;
    localparam logic [TOP_W-1:0] TOP_OFFSET_RST = 7'd18;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_EMIT,
        S_DRAIN
    } t_brs_state;

    // Controller to datapath
    typedef struct packed {
        logic load;      // write one store row
        logic capture;   // latch a draw
        logic div_step;  // one step of the row step divider
        logic issue;     // start one output row
    } t_brs_ctl;

    // Datapath to controller
    typedef struct packed {
        logic zero_height;  // draw on the input emits nothing
        logic div_done;     // final divider step this cycle
        logic last_issue;   // current row is the final one
        logic advance;      // row pipeline may move
        logic pipe_empty;   // no row in flight
    } t_brs_stat;

endpackage

/* rtl/brs_ctrl.sv */
// brs_ctrl: sequencer for loads, step division and row emission.
// Depends on brs_pkg; drives brs_dpath through t_brs_ctl.

module brs_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_cmd,
    output logic                  o_s_tready,
    input  brs_pkg::t_brs_stat    i_stat,
    output brs_pkg::t_brs_ctl     o_ctl
);

    brs_pkg::t_brs_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= brs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_s_tready = 1'b0;
        o_ctl      = '0;
        case (r_state)
            brs_pkg::S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    if (i_cmd == brs_pkg::CMD_LOAD) begin
                        o_ctl.load = 1'b1;
                    end else begin
                        o_ctl.capture = 1'b1;
                        if (!i_stat.zero_height) n_state = brs_pkg::S_DIV;
                    end
                end
            end
            brs_pkg::S_DIV: begin
                o_ctl.div_step = 1'b1;
                if (i_stat.div_done) n_state = brs_pkg::S_EMIT;
            end
            brs_pkg::S_EMIT: begin
                if (i_stat.advance) begin
                    o_ctl.issue = 1'b1;
                    if (i_stat.last_issue) n_state = brs_pkg::S_DRAIN;
                end
            end
            brs_pkg::S_DRAIN: begin
                if (i_stat.pipe_empty) n_state = brs_pkg::S_IDLE;
            end
            default: begin
                n_state = brs_pkg::S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/brs_dpath.sv */
// brs_dpath: sprite store, bit-serial step divider, row accumulator and
// the two-stage row pipeline (store read, output word). Depends on brs_pkg.

module brs_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  brs_pkg::t_brs_ctl             i_ctl,
    output brs_pkg::t_brs_stat            o_stat,
    // input word fields
    input  logic [brs_pkg::LIDX_W-1:0]    i_load_index,
    input  logic [brs_pkg::PIX_W-1:0]     i_load_bits,
    input  logic [brs_pkg::SLOT_W-1:0]    i_player_slot,
    input  logic [brs_pkg::CFG_W-1:0]     i_center_x,
    input  logic [brs_pkg::TOP_W-1:0]     i_top_row,
    input  logic [brs_pkg::CFG_W-1:0]     i_bitmap_height,
    input  logic [brs_pkg::RIU_W-1:0]     i_rows_in_use,
    // registers
    input  logic [brs_pkg::CFG_W-1:0]     i_view_left,
    input  logic [brs_pkg::CFG_W-1:0]     i_view_right,
    input  logic [brs_pkg::TOP_W-1:0]     i_top_offset,
    // output word
    input  logic                          i_m_tready,
    output logic                          o_m_tvalid,
    output logic [brs_pkg::SLOT_W-1:0]    o_slot_out,
    output logic [brs_pkg::ROW_W-1:0]     o_row_pos,
    output logic [brs_pkg::PIX_W-1:0]     o_row_bits,
    output logic [brs_pkg::SIZE_W-1:0]    o_size_code,
    output logic [brs_pkg::ROW_W-1:0]     o_hpos,
    output logic                          o_last
);

    localparam int IDX_W  = brs_pkg::IDX_W;
    localparam int RW     = brs_pkg::RW;
    localparam int NUM_W  = brs_pkg::NUM_W;
    localparam int HGT_W  = brs_pkg::HGT_W;
    localparam int HX_W   = brs_pkg::HX_W;

    logic [brs_pkg::PIX_W-1:0] r_store [brs_pkg::SPRITE_DEPTH];

    // draw context
    logic [brs_pkg::SLOT_W-1:0] r_slot;
    logic [brs_pkg::ROW_W-1:0]  r_row0;
    logic [HGT_W-1:0]           r_height;
    logic [brs_pkg::SIZE_W-1:0] r_size;
    logic signed [HX_W-1:0]     r_left0;
    logic signed [HX_W-1:0]     r_width;
    logic [brs_pkg::ROW_W-1:0]  r_hpos;

    // divider: r_quo starts as the dividend and ends as the step
    logic [HGT_W-1:0]           r_rem;
    logic [NUM_W-1:0]           r_quo;
    logic [brs_pkg::DCNT_W-1:0] r_dcnt;

    // row walk
    logic [NUM_W-1:0]           r_acc;
    logic [HGT_W-1:0]           r_idx;

    // stage A: store read
    logic                       r_a_vld;
    logic [brs_pkg::ROW_W-1:0]  r_a_pos;
    logic                       r_a_last;
    logic [brs_pkg::PIX_W-1:0]  r_rd;

    // stage B: output word
    logic                       r_b_vld;
    logic [brs_pkg::ROW_W-1:0]  r_b_pos;
    logic                       r_b_last;
    logic [brs_pkg::PIX_W-1:0]  r_b_bits;

    logic [HGT_W-1:0]           n_height;
    logic [RW-1:0]              n_rows;
    logic [brs_pkg::SIZE_W-1:0] n_size;
    logic signed [HX_W-1:0]     n_width;
    logic signed [HX_W-1:0]     n_left0;
    logic signed [HX_W-1:0]     n_left;
    logic signed [HX_W-1:0]     n_hposx;
    logic [HGT_W:0]             n_shift;
    logic [HGT_W:0]             n_diff;
    logic                       advance;

    // draw setup
    always_comb begin
        if (int'(i_bitmap_height) > brs_pkg::MAX_HEIGHT) begin
            n_height = HGT_W'(brs_pkg::MAX_HEIGHT);
        end else begin
            n_height = HGT_W'(i_bitmap_height);
        end
        if (int'(i_rows_in_use) > brs_pkg::SPRITE_DEPTH) begin
            n_rows = RW'(brs_pkg::SPRITE_DEPTH);
        end else begin
            n_rows = RW'(i_rows_in_use);
        end
        if (int'(n_height) >= brs_pkg::QUAD_MIN) begin
            n_size  = brs_pkg::SIZE_QUAD;
            n_width = HX_W'(brs_pkg::WIDTH_QUAD);
        end else if (int'(n_height) >= brs_pkg::DOUBLE_MIN) begin
            n_size  = brs_pkg::SIZE_DOUBLE;
            n_width = HX_W'(brs_pkg::WIDTH_DOUBLE);
        end else begin
            n_size  = brs_pkg::SIZE_SINGLE;
            n_width = HX_W'(brs_pkg::WIDTH_SINGLE);
        end
        // raise to the left edge of the view
        n_left0 = $signed({2'b00, i_center_x}) - (n_width >>> 1);
        if (n_left0 < $signed({2'b00, i_view_left})) begin
            n_left0 = $signed({2'b00, i_view_left});
        end
    end

    // second half of the clamp, from the latched context
    always_comb begin
        n_left = r_left0;
        if (r_left0 + r_width > $signed({2'b00, i_view_right}) + HX_W'(1)) begin
            n_left = $signed({2'b00, i_view_right}) + HX_W'(1) - r_width;
        end
        n_hposx = n_left + HX_W'(brs_pkg::HPOS_BASE);
    end

    // restoring divide, one quotient bit a step
    assign n_shift = {r_rem, r_quo[NUM_W-1]};
    assign n_diff  = n_shift - {1'b0, r_height};

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_slot   <= i_player_slot;
            r_row0   <= brs_pkg::ROW_W'(i_top_offset) + brs_pkg::ROW_W'(i_top_row);
            r_height <= n_height;
            r_size   <= n_size;
            r_width  <= n_width;
            r_left0  <= n_left0;
            r_rem    <= '0;
            r_quo    <= {n_rows, brs_pkg::FRAC_W'(0)};
            r_dcnt   <= brs_pkg::DCNT_W'(NUM_W - 1);
            r_acc    <= '0;
            r_idx    <= '0;
        end else if (i_ctl.div_step) begin
            r_hpos <= n_hposx[brs_pkg::ROW_W-1:0];
            r_dcnt <= r_dcnt - 1'b1;
            if (!n_diff[HGT_W]) begin
                r_rem <= n_diff[HGT_W-1:0];
                r_quo <= {r_quo[NUM_W-2:0], 1'b1};
            end else begin
                r_rem <= n_shift[HGT_W-1:0];
                r_quo <= {r_quo[NUM_W-2:0], 1'b0};
            end
        end else if (i_ctl.issue) begin
            r_acc <= r_acc + r_quo;
            r_idx <= r_idx + 1'b1;
        end
    end

    // sprite store
    always_ff @(posedge i_clk) begin
        if (i_ctl.load && (int'(i_load_index) < brs_pkg::SPRITE_DEPTH)) begin
            r_store[IDX_W'(i_load_index)] <= i_load_bits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.issue) begin
            r_rd <= r_store[r_acc[brs_pkg::FRAC_W +: IDX_W]];
        end
    end

    // row pipeline
    assign advance = !r_b_vld || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else if (advance) begin
            r_a_vld <= i_ctl.issue;
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.issue) begin
            r_a_pos  <= r_row0 + brs_pkg::ROW_W'(r_idx);
            r_a_last <= (r_idx == r_height - 1'b1);
        end
        if (advance && r_a_vld) begin
            r_b_pos  <= r_a_pos;
            r_b_last <= r_a_last;
            r_b_bits <= r_rd;
        end
    end

    assign o_stat.zero_height = (i_bitmap_height == '0);
    assign o_stat.div_done    = (r_dcnt == '0);
    assign o_stat.last_issue  = (r_idx == r_height - 1'b1);
    assign o_stat.advance     = advance;
    assign o_stat.pipe_empty  = !r_a_vld && !r_b_vld;

    assign o_m_tvalid  = r_b_vld;
    assign o_slot_out  = r_slot;
    assign o_row_pos   = r_b_pos;
    assign o_row_bits  = r_b_bits;
    assign o_size_code = r_size;
    assign o_hpos      = r_hpos;
    assign o_last      = r_b_last;

    // a row is only started when the pipeline can take it
    a_issue_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.issue |-> advance)
        else $error("row issued into a stalled pipeline");

    // nothing follows the final row of a draw
    a_last_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_vld && r_b_last) |-> !r_a_vld)
        else $error("row queued behind the final row");

    // never issue beyond the height
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.issue |-> (r_idx < r_height))
        else $error("row index beyond height");

    // divider and row walk never overlap
    a_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.div_step |-> (!i_ctl.issue && !r_a_vld && !r_b_vld))
        else $error("divider running with rows in flight");

endmodule

/* rtl/billboard_row_scaler.sv */
// billboard_row_scaler: top level with register file, stream ports and
// instances of brs_ctrl and brs_dpath. Depends on brs_pkg.

// A load word (tuser 0) writes one 8-bit row into a 32-row sprite store and
// produces nothing. A draw word (tuser 1) produces one output word per
// display row, top to bottom, with tlast on the final one; a height of zero
// produces nothing and heights above 64 are taken as 64. The sprite is sampled
// nearest-neighbour with a step of rows*256/height; the width code (single,
// double, quadruple) follows from the height, and hpos is 48 plus the left
// edge clamped into the view window. Words are taken one at a time: a load
// or a zero-height draw leaves the sequencer idle; any other draw is latched,
// runs the bit-serial step divider, sends each row through the store read
// and output register, empties that pipeline and goes back to idle before
// the next word is taken, and the sink can hold this up with tready low.
// The store has no reset: draw only rows already loaded. Registers (APB,
// write at psel&penable&pwrite): 0x0 view left, 0x4 view right, 0x8 top
// offset; write them only while no draw runs.

module billboard_row_scaler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [4:0] load_index, [12:5] load_bits, [14:13] player_slot,
    // [22:15] center_x, [29:23] top_row, [37:30] bitmap_height,
    // [43:38] rows_in_use, [47:44] zero
    input  logic [47:0] i_s_tdata,
    // [0] cmd
    input  logic        i_s_tuser,
    // output stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [7:0] row_pos, [15:8] row_bits, [17:16] size_code, [25:18] hpos,
    // [31:26] zero
    output logic [31:0] o_m_tdata,
    // [1:0] slot_out
    output logic [1:0]  o_m_tuser,
    output logic        o_m_tlast,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [brs_pkg::REG_ADDR_W-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // register file
    logic [brs_pkg::CFG_W-1:0] r_view_left;
    logic [brs_pkg::CFG_W-1:0] r_view_right;
    logic [brs_pkg::TOP_W-1:0] r_top_offset;
    logic [1:0]                reg_sel;
    logic                      cfg_wr;

    assign pready  = 1'b1;
    assign reg_sel = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_view_left  <= brs_pkg::VIEW_LEFT_RST;
            r_view_right <= brs_pkg::VIEW_RIGHT_RST;
            r_top_offset <= brs_pkg::TOP_OFFSET_RST;
        end else if (cfg_wr) begin
            case (reg_sel)
                brs_pkg::REG_VIEW_LEFT:  r_view_left  <= pwdata[brs_pkg::CFG_W-1:0];
                brs_pkg::REG_VIEW_RIGHT: r_view_right <= pwdata[brs_pkg::CFG_W-1:0];
                brs_pkg::REG_TOP_OFFSET: r_top_offset <= pwdata[brs_pkg::TOP_W-1:0];
                default: ;  // unmapped: ignored
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            brs_pkg::REG_VIEW_LEFT:  prdata = 32'(r_view_left);
            brs_pkg::REG_VIEW_RIGHT: prdata = 32'(r_view_right);
            brs_pkg::REG_TOP_OFFSET: prdata = 32'(r_top_offset);
            default:                 prdata = '0;
        endcase
    end

    // control and status between sequencer and datapath
    brs_pkg::t_brs_ctl  ctl;
    brs_pkg::t_brs_stat stat;
    logic               s_ready;

    // load and draw are accepted only while the sequencer is idle
    assign o_s_tready = s_ready;

    brs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_cmd      (i_s_tuser),
        .o_s_tready (s_ready),
        .i_stat     (stat),
        .o_ctl      (ctl)
    );

    logic [brs_pkg::ROW_W-1:0]  row_pos;
    logic [brs_pkg::PIX_W-1:0]  row_bits;
    logic [brs_pkg::SIZE_W-1:0] size_code;
    logic [brs_pkg::ROW_W-1:0]  hpos;

    brs_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (ctl),
        .o_stat          (stat),
        .i_load_index    (i_s_tdata[4:0]),
        .i_load_bits     (i_s_tdata[12:5]),
        .i_player_slot   (i_s_tdata[14:13]),
        .i_center_x      (i_s_tdata[22:15]),
        .i_top_row       (i_s_tdata[29:23]),
        .i_bitmap_height (i_s_tdata[37:30]),
        .i_rows_in_use   (i_s_tdata[43:38]),
        .i_view_left     (r_view_left),
        .i_view_right    (r_view_right),
        .i_top_offset    (r_top_offset),
        .i_m_tready      (i_m_tready),
        .o_m_tvalid      (o_m_tvalid),
        .o_slot_out      (o_m_tuser),
        .o_row_pos       (row_pos),
        .o_row_bits      (row_bits),
        .o_size_code     (size_code),
        .o_hpos          (hpos),
        .o_last          (o_m_tlast)
    );

    // pack the output word, first field lowest
    assign o_m_tdata = {6'd0, hpos, size_code, row_bits, row_pos};

endmodule
